// ===== sv/btff_pkg.sv =====
// Shared types and constants for the boundary-tag first-fit allocator.
// Holds field widths, tag layout, command/status structs and select codes.
// Used by btff_ctrl, btff_dp and the top level.
package btff_pkg;

    localparam int STORE_BYTES_DEF = 8192;

    // Field widths
    localparam int HB_W    = 14;
    localparam int REQ_W   = 13;
    localparam int ADDR_W  = 13;
    localparam int BLK_W   = 12;
    localparam int BYTE_W  = 13;
    localparam int SIZE_W  = 15;
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;

    // Tag layout
    localparam int TAG_BYTES = 2;
    localparam int SPLIT_MIN = 2 * TAG_BYTES + 1;
    localparam int MIN_SPAN  = 10;
    localparam int USED_BIT  = 7;

    localparam logic [BYTE_W-1:0] MAX_BYTES  = '1;
    localparam logic [BLK_W-1:0]  MAX_BLOCKS = '1;
    localparam logic [ADDR_W-1:0] MAX_FREE   = '1;

    localparam logic [HB_W-1:0]    HEAP_BYTES_RST = 14'd8192;
    localparam logic [PADDR_W-1:0] REG_HEAP_BYTES = 2'd0;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Walk pointer sources
    localparam logic [2:0] SP_HOLD = 3'd0;
    localparam logic [2:0] SP_ZERO = 3'd1;
    localparam logic [2:0] SP_PTR  = 3'd2;
    localparam logic [2:0] SP_HEND = 3'd3;
    localparam logic [2:0] SP_TAIL = 3'd4;
    localparam logic [2:0] SP_TEND = 3'd5;

    // Tag write selections
    localparam logic [1:0] WS_FORMAT = 2'd0;
    localparam logic [1:0] WS_REST   = 2'd1;
    localparam logic [1:0] WS_USED   = 2'd2;
    localparam logic [1:0] WS_MERGED = 2'd3;

    // Tag byte order within a write
    localparam logic [1:0] WB_HEAD_HI = 2'd0;
    localparam logic [1:0] WB_HEAD_LO = 2'd1;
    localparam logic [1:0] WB_TAIL_HI = 2'd2;
    localparam logic [1:0] WB_TAIL_LO = 2'd3;

    typedef struct packed {
        logic       item_load;
        logic [2:0] s_op;
        logic       rd_ofs;
        logic       hi_load;
        logic       lo_load;
        logic       blk_load;
        logic       t_load;
        logic       prev_merge;
        logic       next_merge;
        logic       best_clr;
        logic       best_upd;
        logic       w_load;
        logic [1:0] w_sel;
        logic       wr_en;
        logic [1:0] wr_idx;
        logic       cnt_alloc;
        logic       cnt_free;
        logic       cnt_clr;
        logic       ok_set;
        logic       res_load;
        logic       clr_en;
        logic       fmt_ack;
    } cmd_t;

    typedef struct packed {
        logic fmt_req;
        logic clr_last;
        logic head_pre;
        logic head_valid;
        logic tail_pre;
        logic tail_valid;
        logic tfree;
        logic fit;
        logic dsmall;
        logic ptr_ok;
        logic out_free;
    } sts_t;

endpackage

// ===== sv/boundary_tag_first_fit_allocator_core.sv =====
// Boundary-tag first-fit allocator over a byte store.
// Items enter on in_valid/in_stall: operation (0 allocate, 1 free),
// request_bytes and block_address. One result per item leaves on
// out_valid/out_stall with success, payload_address, the two usage
// counters and the largest free payload size.
// Each item runs a variable sequence: an allocation's first-fit search
// visits blocks, a free reads its own tag and the tags of its neighbours,
// every tag is written byte by byte, then a closing scan visits the blocks
// to find the largest free block; all of it is serialized on the single
// store read port. One item is in work at a time; the next is taken once
// the result sits in the output register. If the receiver stalls, the
// result holds and the following item waits until the output register frees.
// After reset the store is swept to zero, one byte a cycle, then formatted
// as one free block; in_stall stays high meanwhile.
// Writing heap_bytes over the APB port reformats the store and clears the
// counters before the next item is taken.
module boundary_tag_first_fit_allocator_core #(
    parameter int STORE_BYTES = btff_pkg::STORE_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [btff_pkg::PADDR_W-1:0] paddr,
    input  logic [btff_pkg::PDATA_W-1:0] pwdata,
    output logic [btff_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         operation,
    input  logic [btff_pkg::REQ_W-1:0]   request_bytes,
    input  logic [btff_pkg::ADDR_W-1:0]  block_address,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         success,
    output logic [btff_pkg::ADDR_W-1:0]  payload_address,
    output logic [btff_pkg::BLK_W-1:0]   blocks_in_use,
    output logic [btff_pkg::BYTE_W-1:0]  bytes_in_use,
    output logic [btff_pkg::ADDR_W-1:0]  largest_free
);
    import btff_pkg::*;

    cmd_t            cmd;
    sts_t            sts;
    logic            cfg_we;
    logic [HB_W-1:0] heap_bytes;

    // APB register access
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == REG_HEAP_BYTES);
    assign prdata = (paddr == REG_HEAP_BYTES) ? PDATA_W'(heap_bytes) : '0;

    btff_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .in_stall  (in_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    btff_dp #(
        .STORE_BYTES (STORE_BYTES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_we          (cfg_we),
        .cfg_wdata       (pwdata[HB_W-1:0]),
        .heap_bytes      (heap_bytes),
        .request_bytes   (request_bytes),
        .block_address   (block_address),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .success         (success),
        .payload_address (payload_address),
        .blocks_in_use   (blocks_in_use),
        .bytes_in_use    (bytes_in_use),
        .largest_free    (largest_free)
    );

`ifndef NO_ASSERTIONS
    // an accepted item keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item accepted on back-to-back cycles");

    // only a successful allocation reports an address
    a_addr_means_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (payload_address != '0) |-> success)
        else $error("address reported without success");

    // largest free block never exceeds the store
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(largest_free) <= 32'(STORE_BYTES - 4)))
        else $error("largest free block out of range");

    // a new result is never loaded over one still held by the receiver
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> sts.out_free)
        else $error("result overwritten");
`endif
endmodule

// ===== sv/btff_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module btff_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== sv/btff_ctrl.sv =====
// Sequencer for the allocator: clearing pass, format, allocate, free, scan.
// Drives btff_pkg::cmd_t to the datapath and reads btff_pkg::sts_t back.
module btff_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          operation,
    output logic          in_stall,
    input  btff_pkg::sts_t sts,
    output btff_pkg::cmd_t cmd
);
    import btff_pkg::*;

    localparam logic [4:0] S_CLR     = 5'd0;
    localparam logic [4:0] S_FMT     = 5'd1;
    localparam logic [4:0] S_IDLE    = 5'd2;
    localparam logic [4:0] S_A_CHK   = 5'd3;
    localparam logic [4:0] S_A_EV    = 5'd4;
    localparam logic [4:0] S_A_SPLIT = 5'd5;
    localparam logic [4:0] S_A_USED  = 5'd6;
    localparam logic [4:0] S_F_CHK   = 5'd7;
    localparam logic [4:0] S_F_HEAD  = 5'd8;
    localparam logic [4:0] S_F_HEV   = 5'd9;
    localparam logic [4:0] S_F_PREV  = 5'd10;
    localparam logic [4:0] S_F_PEV   = 5'd11;
    localparam logic [4:0] S_F_NXT   = 5'd12;
    localparam logic [4:0] S_F_NEV   = 5'd13;
    localparam logic [4:0] S_F_WR    = 5'd14;
    localparam logic [4:0] S_WALK0   = 5'd15;
    localparam logic [4:0] S_WALK    = 5'd16;
    localparam logic [4:0] S_W_EV    = 5'd17;
    localparam logic [4:0] S_DONE    = 5'd18;
    localparam logic [4:0] S_RD0     = 5'd19;
    localparam logic [4:0] S_RD1     = 5'd20;
    localparam logic [4:0] S_RD2     = 5'd21;
    localparam logic [4:0] S_W0      = 5'd22;
    localparam logic [4:0] S_W1      = 5'd23;
    localparam logic [4:0] S_W2      = 5'd24;
    localparam logic [4:0] S_W3      = 5'd25;

    logic [4:0] state_reg, state_next;
    logic [4:0] rd_ret_reg, rd_ret_next;
    logic [4:0] wr_ret_reg, wr_ret_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            rd_ret_reg <= S_IDLE;
            wr_ret_reg <= S_IDLE;
        end
        else
        begin
            state_reg  <= state_next;
            rd_ret_reg <= rd_ret_next;
            wr_ret_reg <= wr_ret_next;
        end
    end

    assign in_stall = !(state_reg == S_IDLE && !sts.fmt_req);

    // Next state and commands
    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        rd_ret_next = rd_ret_reg;
        wr_ret_next = wr_ret_reg;
        case (state_reg)
            S_CLR:
            begin
                cmd.clr_en = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_FMT;
                end
            end
            S_FMT:
            begin
                cmd.w_load  = 1'b1;
                cmd.w_sel   = WS_FORMAT;
                cmd.cnt_clr = 1'b1;
                cmd.fmt_ack = 1'b1;
                wr_ret_next = S_IDLE;
                state_next  = S_W0;
            end
            S_IDLE:
            begin
                if (sts.fmt_req)
                begin
                    state_next = S_FMT;
                end
                else if (in_valid)
                begin
                    cmd.item_load = 1'b1;
                    cmd.s_op      = SP_ZERO;
                    state_next    = (operation == OP_ALLOC) ? S_A_CHK : S_F_CHK;
                end
            end
            // first-fit search
            S_A_CHK:
            begin
                if (sts.head_pre)
                begin
                    rd_ret_next = S_A_EV;
                    state_next  = S_RD0;
                end
                else
                begin
                    state_next = S_WALK0;
                end
            end
            S_A_EV:
            begin
                if (!sts.head_valid)
                begin
                    state_next = S_WALK0;
                end
                else if (sts.fit)
                begin
                    cmd.blk_load = 1'b1;
                    state_next   = S_A_SPLIT;
                end
                else
                begin
                    cmd.s_op   = SP_HEND;
                    state_next = S_A_CHK;
                end
            end
            S_A_SPLIT:
            begin
                if (sts.dsmall)
                begin
                    state_next = S_A_USED;
                end
                else
                begin
                    cmd.w_load  = 1'b1;
                    cmd.w_sel   = WS_REST;
                    wr_ret_next = S_A_USED;
                    state_next  = S_W0;
                end
            end
            S_A_USED:
            begin
                cmd.w_load    = 1'b1;
                cmd.w_sel     = WS_USED;
                cmd.cnt_alloc = 1'b1;
                cmd.ok_set    = 1'b1;
                wr_ret_next   = S_WALK0;
                state_next    = S_W0;
            end
            // free with coalescing
            S_F_CHK:
            begin
                if (sts.ptr_ok)
                begin
                    cmd.s_op   = SP_PTR;
                    state_next = S_F_HEAD;
                end
                else
                begin
                    state_next = S_WALK0;
                end
            end
            S_F_HEAD:
            begin
                if (sts.head_pre)
                begin
                    rd_ret_next = S_F_HEV;
                    state_next  = S_RD0;
                end
                else
                begin
                    state_next = S_WALK0;
                end
            end
            S_F_HEV:
            begin
                if (sts.head_valid && !sts.tfree)
                begin
                    cmd.t_load = 1'b1;
                    state_next = S_F_PREV;
                end
                else
                begin
                    state_next = S_WALK0;
                end
            end
            S_F_PREV:
            begin
                if (sts.tail_pre)
                begin
                    cmd.s_op    = SP_TAIL;
                    rd_ret_next = S_F_PEV;
                    state_next  = S_RD0;
                end
                else
                begin
                    cmd.s_op   = SP_TEND;
                    state_next = S_F_NXT;
                end
            end
            S_F_PEV:
            begin
                if (sts.tail_valid && sts.tfree)
                begin
                    cmd.prev_merge = 1'b1;
                end
                cmd.s_op   = SP_TEND;
                state_next = S_F_NXT;
            end
            S_F_NXT:
            begin
                if (sts.head_pre)
                begin
                    rd_ret_next = S_F_NEV;
                    state_next  = S_RD0;
                end
                else
                begin
                    state_next = S_F_WR;
                end
            end
            S_F_NEV:
            begin
                if (sts.head_valid && sts.tfree)
                begin
                    cmd.next_merge = 1'b1;
                end
                state_next = S_F_WR;
            end
            S_F_WR:
            begin
                cmd.w_load   = 1'b1;
                cmd.w_sel    = WS_MERGED;
                cmd.cnt_free = 1'b1;
                cmd.ok_set   = 1'b1;
                wr_ret_next  = S_WALK0;
                state_next   = S_W0;
            end
            // largest free block scan
            S_WALK0:
            begin
                cmd.s_op     = SP_ZERO;
                cmd.best_clr = 1'b1;
                state_next   = S_WALK;
            end
            S_WALK:
            begin
                if (sts.head_pre)
                begin
                    rd_ret_next = S_W_EV;
                    state_next  = S_RD0;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_W_EV:
            begin
                if (sts.head_valid)
                begin
                    cmd.best_upd = 1'b1;
                    cmd.s_op     = SP_HEND;
                    state_next   = S_WALK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            // tag read: two bytes from the registered read port
            S_RD0:
            begin
                cmd.rd_ofs = 1'b0;
                state_next = S_RD1;
            end
            S_RD1:
            begin
                cmd.rd_ofs  = 1'b1;
                cmd.hi_load = 1'b1;
                state_next  = S_RD2;
            end
            S_RD2:
            begin
                cmd.lo_load = 1'b1;
                state_next  = rd_ret_reg;
            end
            // tag write: head pair then tail pair
            S_W0:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_idx = WB_HEAD_HI;
                state_next = S_W1;
            end
            S_W1:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_idx = WB_HEAD_LO;
                state_next = S_W2;
            end
            S_W2:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_idx = WB_TAIL_HI;
                state_next = S_W3;
            end
            S_W3:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_idx = WB_TAIL_LO;
                state_next = wr_ret_reg;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

// ===== sv/btff_dp.sv =====
// Datapath of the allocator: heap store, walk pointer, tag decode,
// counters, size register and result register. Uses btff_pkg and btff_ram.
module btff_dp #(
    parameter int STORE_BYTES = btff_pkg::STORE_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  btff_pkg::cmd_t              cmd,
    output btff_pkg::sts_t              sts,
    input  logic                        cfg_we,
    input  logic [btff_pkg::HB_W-1:0]   cfg_wdata,
    output logic [btff_pkg::HB_W-1:0]   heap_bytes,
    input  logic [btff_pkg::REQ_W-1:0]  request_bytes,
    input  logic [btff_pkg::ADDR_W-1:0] block_address,
    input  logic                        out_stall,
    output logic                        out_valid,
    output logic                        success,
    output logic [btff_pkg::ADDR_W-1:0] payload_address,
    output logic [btff_pkg::BLK_W-1:0]  blocks_in_use,
    output logic [btff_pkg::BYTE_W-1:0] bytes_in_use,
    output logic [btff_pkg::ADDR_W-1:0] largest_free
);
    import btff_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);
    localparam int PW = AW + 1;
    localparam int EW = ((PW > SIZE_W) ? PW : SIZE_W) + 2;
    localparam logic [EW-1:0] TAG2 = EW'(2 * TAG_BYTES);

    // control state
    logic [HB_W-1:0]   hb_reg;
    logic              fmt_req_reg;
    logic [AW-1:0]     clr_reg;
    logic [BLK_W-1:0]  blk_cnt_reg;
    logic [BYTE_W-1:0] byte_cnt_reg;
    logic              out_valid_reg;

    // working registers
    logic [EW-1:0]     s_reg, s_next;
    logic [7:0]        hi_reg, lo_reg;
    logic [EW-1:0]     b_start_reg, b_end_reg;
    logic [SIZE_W-1:0] b_size_reg;
    logic [EW-1:0]     t_start_reg, t_end_reg;
    logic [SIZE_W-1:0] t_size_reg;
    logic [EW-1:0]     st_m_reg, en_m_reg;
    logic [SIZE_W-1:0] best_reg;
    logic [EW-1:0]     w_start_reg, w_end_reg;
    logic [SIZE_W-1:0] w_size_reg;
    logic              w_free_reg;
    logic [REQ_W-1:0]  req_reg;
    logic [ADDR_W-1:0] ptr_reg;
    logic              ok_reg;
    logic [ADDR_W-1:0] addr_reg;

    // result register
    logic              res_ok_reg;
    logic [ADDR_W-1:0] res_addr_reg;
    logic [BLK_W-1:0]  res_blk_reg;
    logic [BYTE_W-1:0] res_byte_reg;
    logic [ADDR_W-1:0] res_free_reg;

    logic [EW-1:0]     hb_ext, span;
    logic [SIZE_W-1:0] tsize, dsize, alloc_size;
    logic [EW-1:0]     tsize_ext, hend, req_ext, used_end;
    logic              tfree, dsmall;
    logic [EW-1:0]     w_start_next, w_end_next;
    logic [SIZE_W-1:0] w_size_next;
    logic              w_free_next;
    logic [EW-1:0]     wa_full;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [7:0]        ram_wdata, ram_rdata;
    logic [SIZE_W:0]   byte_sum;
    logic [SIZE_W-1:0] byte_ext;

    // Span in use, clamped between MIN_SPAN and the store size
    assign hb_ext = EW'(hb_reg);
    always_comb
    begin
        if (hb_ext < EW'(MIN_SPAN))
        begin
            span = EW'(MIN_SPAN);
        end
        else if (hb_ext > EW'(STORE_BYTES))
        begin
            span = EW'(STORE_BYTES);
        end
        else
        begin
            span = hb_ext;
        end
    end

    // Tag decode
    assign tsize      = {hi_reg[6:0], lo_reg};
    assign tfree      = !hi_reg[USED_BIT];
    assign tsize_ext  = EW'(tsize);
    assign hend       = s_reg + tsize_ext + TAG2;
    assign req_ext    = EW'(req_reg);
    assign dsize      = b_size_reg - SIZE_W'(req_reg);
    assign dsmall     = dsize < SIZE_W'(SPLIT_MIN);
    assign alloc_size = dsmall ? b_size_reg : SIZE_W'(req_reg);
    assign used_end   = dsmall ? b_end_reg : b_start_reg + req_ext + TAG2;

    assign sts.fmt_req    = fmt_req_reg;
    assign sts.clr_last   = clr_reg == AW'(STORE_BYTES - 1);
    assign sts.head_pre   = s_reg + TAG2 <= span;
    assign sts.head_valid = hend <= span;
    assign sts.tail_pre   = t_start_reg >= TAG2;
    assign sts.tail_valid = tsize_ext + TAG2 <= s_reg + EW'(TAG_BYTES);
    assign sts.tfree      = tfree;
    assign sts.fit        = tfree && (tsize >= SIZE_W'(req_reg));
    assign sts.dsmall     = dsmall;
    assign sts.ptr_ok     = ptr_reg >= ADDR_W'(TAG_BYTES);
    assign sts.out_free   = !out_valid_reg || !out_stall;

    // Walk pointer source
    always_comb
    begin
        case (cmd.s_op)
            SP_ZERO: s_next = '0;
            SP_PTR:  s_next = EW'(ptr_reg) - EW'(TAG_BYTES);
            SP_HEND: s_next = hend;
            SP_TAIL: s_next = t_start_reg - EW'(TAG_BYTES);
            SP_TEND: s_next = t_end_reg;
            default: s_next = s_reg;
        endcase
    end

    // Tag write descriptor
    always_comb
    begin
        case (cmd.w_sel)
            WS_FORMAT:
            begin
                w_start_next = '0;
                w_end_next   = span;
                w_size_next  = SIZE_W'(span - TAG2);
                w_free_next  = 1'b1;
            end
            WS_REST:
            begin
                w_start_next = b_start_reg + req_ext + TAG2;
                w_end_next   = b_end_reg;
                w_size_next  = dsize - SIZE_W'(2 * TAG_BYTES);
                w_free_next  = 1'b1;
            end
            WS_USED:
            begin
                w_start_next = b_start_reg;
                w_end_next   = used_end;
                w_size_next  = alloc_size;
                w_free_next  = 1'b0;
            end
            default:
            begin
                w_start_next = st_m_reg;
                w_end_next   = en_m_reg;
                w_size_next  = SIZE_W'(en_m_reg - st_m_reg - TAG2);
                w_free_next  = 1'b1;
            end
        endcase
    end

    // Store port selection
    always_comb
    begin
        case (cmd.wr_idx)
            WB_HEAD_HI: wa_full = w_start_reg;
            WB_HEAD_LO: wa_full = w_start_reg + EW'(1);
            WB_TAIL_HI: wa_full = w_end_reg - EW'(TAG_BYTES);
            default:    wa_full = w_end_reg - EW'(1);
        endcase
    end

    assign ram_we    = cmd.wr_en || cmd.clr_en;
    assign ram_waddr = cmd.clr_en ? clr_reg : AW'(wa_full);
    assign ram_wdata = cmd.clr_en ? 8'd0 :
                       (cmd.wr_idx[0] ? w_size_reg[7:0] : {!w_free_reg, w_size_reg[14:8]});
    assign ram_raddr = AW'(s_reg + EW'(cmd.rd_ofs));

    btff_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign byte_ext = SIZE_W'(byte_cnt_reg);
    assign byte_sum = (SIZE_W + 1)'(byte_cnt_reg) + (SIZE_W + 1)'(alloc_size);

    // Control state: size register, format request, clear sweep, counters, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hb_reg        <= HEAP_BYTES_RST;
            fmt_req_reg   <= 1'b1;
            clr_reg       <= '0;
            blk_cnt_reg   <= '0;
            byte_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                hb_reg      <= cfg_wdata;
                fmt_req_reg <= 1'b1;
            end
            else if (cmd.fmt_ack)
            begin
                fmt_req_reg <= 1'b0;
            end
            if (cmd.clr_en)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cmd.cnt_clr)
            begin
                blk_cnt_reg  <= '0;
                byte_cnt_reg <= '0;
            end
            else if (cmd.cnt_alloc)
            begin
                byte_cnt_reg <= (byte_sum > (SIZE_W + 1)'(MAX_BYTES)) ?
                                MAX_BYTES : BYTE_W'(byte_sum);
                if (blk_cnt_reg < MAX_BLOCKS)
                begin
                    blk_cnt_reg <= blk_cnt_reg + BLK_W'(1);
                end
            end
            else if (cmd.cnt_free)
            begin
                byte_cnt_reg <= (byte_ext > t_size_reg) ?
                                BYTE_W'(byte_ext - t_size_reg) : '0;
                if (blk_cnt_reg != '0)
                begin
                    blk_cnt_reg <= blk_cnt_reg - BLK_W'(1);
                end
            end
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
        if (cmd.item_load)
        begin
            req_reg  <= request_bytes;
            ptr_reg  <= block_address;
            ok_reg   <= 1'b0;
            addr_reg <= '0;
        end
        if (cmd.hi_load)
        begin
            hi_reg <= ram_rdata;
        end
        if (cmd.lo_load)
        begin
            lo_reg <= ram_rdata;
        end
        if (cmd.blk_load)
        begin
            b_start_reg <= s_reg;
            b_end_reg   <= hend;
            b_size_reg  <= tsize;
        end
        if (cmd.t_load)
        begin
            t_start_reg <= s_reg;
            t_end_reg   <= hend;
            t_size_reg  <= tsize;
            st_m_reg    <= s_reg;
            en_m_reg    <= hend;
        end
        if (cmd.prev_merge)
        begin
            st_m_reg <= t_start_reg - tsize_ext - TAG2;
        end
        if (cmd.next_merge)
        begin
            en_m_reg <= hend;
        end
        if (cmd.best_clr)
        begin
            best_reg <= '0;
        end
        else if (cmd.best_upd && tfree && (tsize > best_reg))
        begin
            best_reg <= tsize;
        end
        if (cmd.w_load)
        begin
            w_start_reg <= w_start_next;
            w_end_reg   <= w_end_next;
            w_size_reg  <= w_size_next;
            w_free_reg  <= w_free_next;
        end
        if (cmd.ok_set)
        begin
            ok_reg <= 1'b1;
        end
        if (cmd.cnt_alloc)
        begin
            addr_reg <= ADDR_W'(b_start_reg + EW'(TAG_BYTES));
        end
        if (cmd.res_load)
        begin
            res_ok_reg   <= ok_reg;
            res_addr_reg <= addr_reg;
            res_blk_reg  <= blk_cnt_reg;
            res_byte_reg <= byte_cnt_reg;
            res_free_reg <= (best_reg > SIZE_W'(MAX_FREE)) ? MAX_FREE : ADDR_W'(best_reg);
        end
    end

    assign heap_bytes      = hb_reg;
    assign out_valid       = out_valid_reg;
    assign success         = res_ok_reg;
    assign payload_address = res_addr_reg;
    assign blocks_in_use   = res_blk_reg;
    assign bytes_in_use    = res_byte_reg;
    assign largest_free    = res_free_reg;
endmodule
